// File: design/apr_pkg.sv
// Package for the aging page replacement block.
// Holds the sequencer state type and the control bundle for the head cell.
// No dependencies.
`default_nettype none
package apr_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_ACCESS,
		ST_EVICT,
		ST_TICK,
		ST_FINISH
	} state_t;

	// Control from the sequencer to the head cell
	typedef struct packed {
		state_t mode;
		logic   is_write;
		logic   at_vp;
		logic   load;
		logic   kill;
	} head_ctl_t;

endpackage
`default_nettype wire

// File: design/apr_cell.sv
// One page-table cell of the rotating ring.
// Holds one entry and takes its neighbor's entry on every shift.
// Depends on nothing.
`default_nettype none
module apr_cell #(
	parameter int FRW      = 6,
	parameter int AGE_BITS = 8
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                shift,
	input  wire logic                in_p,
	input  wire logic                in_r,
	input  wire logic                in_m,
	input  wire logic [FRW-1:0]      in_fr,
	input  wire logic [AGE_BITS-1:0] in_age,
	output logic                     out_p,
	output logic                     out_r,
	output logic                     out_m,
	output logic [FRW-1:0]           out_fr,
	output logic [AGE_BITS-1:0]      out_age
);

	logic                p_q, r_q, m_q;
	logic [FRW-1:0]      fr_q;
	logic [AGE_BITS-1:0] age_q;

	// entry register, cleared at reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= 1'b0;
			r_q   <= 1'b0;
			m_q   <= 1'b0;
			fr_q  <= '0;
			age_q <= '0;
		end else if (shift) begin
			p_q   <= in_p;
			r_q   <= in_r;
			m_q   <= in_m;
			fr_q  <= in_fr;
			age_q <= in_age;
		end
	end

	assign out_p   = p_q;
	assign out_r   = r_q;
	assign out_m   = m_q;
	assign out_fr  = fr_q;
	assign out_age = age_q;

endmodule
`default_nettype wire

// File: design/apr_head.sv
// Head cell: updates the entry leaving the front of the ring.
// Applies aging, hit marking, victim clearing and page load.
// Depends on apr_pkg.
`default_nettype none
module apr_head #(
	parameter int FRW      = 6,
	parameter int AGE_BITS = 8
) (
	input  wire apr_pkg::head_ctl_t   ctl,
	input  wire logic [FRW-1:0]       fr_new,
	input  wire logic                 in_p,
	input  wire logic                 in_r,
	input  wire logic                 in_m,
	input  wire logic [FRW-1:0]       in_fr,
	input  wire logic [AGE_BITS-1:0]  in_age,
	output logic                      out_p,
	output logic                      out_r,
	output logic                      out_m,
	output logic [FRW-1:0]            out_fr,
	output logic [AGE_BITS-1:0]       out_age
);

	always_comb begin
		out_p   = in_p;
		out_r   = in_r;
		out_m   = in_m;
		out_fr  = in_fr;
		out_age = in_age;
		case (ctl.mode)
			apr_pkg::ST_TICK: begin
				out_age = in_age >> 1;
				if (in_p && in_r) begin
					out_age[AGE_BITS-1] = 1'b1;
					out_r = 1'b0;
				end
			end
			apr_pkg::ST_ACCESS: begin
				if (ctl.at_vp && in_p) begin
					out_r = 1'b1;
					out_m = in_m | ctl.is_write;
				end
			end
			default: ;
		endcase
		// evicted page is wiped
		if (ctl.kill) begin
			out_p   = 1'b0;
			out_r   = 1'b0;
			out_m   = 1'b0;
			out_fr  = '0;
			out_age = '0;
		end
		// new page arrives with clean bits
		if (ctl.load) begin
			out_p   = 1'b1;
			out_r   = 1'b0;
			out_m   = 1'b0;
			out_fr  = fr_new;
			out_age = '0;
		end
	end

endmodule
`default_nettype wire

// File: design/aging_page_replacement.sv
// Aging page replacement unit: a ring of page-table cells and a sequencer.
// Input beat: tuser = func (0 access, 1 tick); tdata = virt_page, is_write.
// Output beat: tdata = hit, frame, evicted, victim_page; one per input beat.
// The page table is a ring of VIRT_PAGES cells that rotates one place per
// cycle while a pass runs; the head cell updates each entry as it passes the front.
// A tick or an access takes one full turn of the ring. A miss with all
// frames in use takes a second turn to clear the victim and load the page.
// One item is in the ring at a time; s_tready is high only while idle.
// The finished result sits in an output register; a new item can be
// accepted while it waits. If the receiver stalls, the next item's result
// waits in the sequencer until the output register empties.
// Reset (arst_n low) clears every cell, the frame count and the output
// register at once; the block is ready on the first cycle after reset.
// Frames are handed out in order until FRAMES are used; after that the
// present page of smallest age, lowest page on a tie, is evicted.
`default_nettype none
module aging_page_replacement #(
	parameter int VIRT_PAGES = 128,
	parameter int FRAMES     = 64,
	parameter int AGE_BITS   = 8,
	localparam int VPW = $clog2(VIRT_PAGES),
	localparam int FRW = (FRAMES > 1) ? $clog2(FRAMES) : 1,
	localparam int IW  = ((VPW + 1 + 7) / 8) * 8,
	localparam int OW  = ((FRW + VPW + 2 + 7) / 8) * 8
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          s_tvalid,
	output logic               s_tready,
	input  wire logic [IW-1:0] s_tdata,   // virt_page, is_write
	input  wire logic          s_tuser,   // func
	output logic               m_tvalid,
	input  wire logic          m_tready,
	output logic [OW-1:0]      m_tdata    // hit, frame, evicted, victim_page
);

	localparam int FUW = $clog2(FRAMES + 1);

	apr_pkg::state_t   state_q, state_d;
	logic [VPW-1:0]    idx_q, vp_q, vic_q;
	logic              wr_q, hit_q, ev_q, full_q, found_q;
	logic [FRW-1:0]    fr_q, vfr_q;
	logic [FUW-1:0]    fu_q;
	logic [AGE_BITS-1:0] best_q;
	logic              out_valid_q, out_hit_q, out_ev_q;
	logic [FRW-1:0]    out_fr_q;
	logic [VPW-1:0]    out_vic_q;

	logic              shift, last, at_vp, free, accept, emit, is_full;
	logic [VPW-1:0]    vp_raw, vp_in;
	logic [FRW-1:0]    fr_new;
	apr_pkg::head_ctl_t ctl;

	// ring of cells
	logic                c_p [VIRT_PAGES];
	logic                c_r [VIRT_PAGES];
	logic                c_m [VIRT_PAGES];
	logic [FRW-1:0]      c_fr [VIRT_PAGES];
	logic [AGE_BITS-1:0] c_age [VIRT_PAGES];
	logic                h_p, h_r, h_m;
	logic [FRW-1:0]      h_fr;
	logic [AGE_BITS-1:0] h_age;

	genvar gi;
	generate
		for (gi = 0; gi < VIRT_PAGES; gi++) begin : g_cell
			if (gi == VIRT_PAGES - 1) begin : g_tail
				apr_cell #(.FRW(FRW), .AGE_BITS(AGE_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.in_p(h_p), .in_r(h_r), .in_m(h_m), .in_fr(h_fr), .in_age(h_age),
					.out_p(c_p[gi]), .out_r(c_r[gi]), .out_m(c_m[gi]),
					.out_fr(c_fr[gi]), .out_age(c_age[gi])
				);
			end else begin : g_mid
				apr_cell #(.FRW(FRW), .AGE_BITS(AGE_BITS)) u_cell (
					.clk(clk), .arst_n(arst_n), .shift(shift),
					.in_p(c_p[gi+1]), .in_r(c_r[gi+1]), .in_m(c_m[gi+1]),
					.in_fr(c_fr[gi+1]), .in_age(c_age[gi+1]),
					.out_p(c_p[gi]), .out_r(c_r[gi]), .out_m(c_m[gi]),
					.out_fr(c_fr[gi]), .out_age(c_age[gi])
				);
			end
		end
	endgenerate

	// head cell control
	assign vp_raw = s_tdata[VPW-1:0];
	assign vp_in  = ({1'b0, vp_raw} >= (VPW+1)'(VIRT_PAGES)) ?
		VPW'({1'b0, vp_raw} - (VPW+1)'(VIRT_PAGES)) : vp_raw;
	assign shift  = (state_q == apr_pkg::ST_ACCESS) || (state_q == apr_pkg::ST_EVICT) ||
		(state_q == apr_pkg::ST_TICK);
	assign last   = (idx_q == VPW'(VIRT_PAGES - 1));
	assign at_vp  = (idx_q == vp_q);
	assign free   = (fu_q < FUW'(FRAMES));
	assign fr_new = (state_q == apr_pkg::ST_EVICT) ? fr_q : fu_q[FRW-1:0];
	assign accept = s_tvalid && s_tready;
	assign emit   = (state_q == apr_pkg::ST_FINISH) && !full_q && (!out_valid_q || m_tready);

	always_comb begin
		ctl.mode     = state_q;
		ctl.is_write = wr_q;
		ctl.at_vp    = at_vp;
		ctl.load     = ((state_q == apr_pkg::ST_ACCESS) && at_vp && !c_p[0] && free) ||
			((state_q == apr_pkg::ST_EVICT) && at_vp);
		ctl.kill     = (state_q == apr_pkg::ST_EVICT) && ev_q && (idx_q == vic_q);
	end

	apr_head #(.FRW(FRW), .AGE_BITS(AGE_BITS)) u_head (
		.ctl(ctl), .fr_new(fr_new),
		.in_p(c_p[0]), .in_r(c_r[0]), .in_m(c_m[0]), .in_fr(c_fr[0]), .in_age(c_age[0]),
		.out_p(h_p), .out_r(h_r), .out_m(h_m), .out_fr(h_fr), .out_age(h_age)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= apr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		case (state_q)
			apr_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					state_d = s_tuser ? apr_pkg::ST_TICK : apr_pkg::ST_ACCESS;
				end
			end
			apr_pkg::ST_ACCESS, apr_pkg::ST_EVICT, apr_pkg::ST_TICK: begin
				if (last) begin
					state_d = apr_pkg::ST_FINISH;
				end
			end
			apr_pkg::ST_FINISH: begin
				if (full_q) begin
					state_d = apr_pkg::ST_EVICT;
				end else if (emit) begin
					state_d = apr_pkg::ST_IDLE;
				end
			end
			default: state_d = apr_pkg::ST_IDLE;
		endcase
	end

	// sequencer control: ring position and frame count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q <= '0;
			fu_q  <= '0;
		end else begin
			if (shift) begin
				idx_q <= last ? '0 : idx_q + 1'b1;
			end
			if ((state_q == apr_pkg::ST_ACCESS) && at_vp && !c_p[0] && free) begin
				fu_q <= fu_q + 1'b1;
			end
		end
	end

	// lookup result and victim search
	assign is_full = (state_q == apr_pkg::ST_FINISH) && full_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q <= 1'b0;
		end else if (accept) begin
			full_q <= 1'b0;
		end else if ((state_q == apr_pkg::ST_ACCESS) && at_vp) begin
			full_q <= !c_p[0] && !free;
		end else if (is_full) begin
			full_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			vp_q    <= vp_in;
			wr_q    <= s_tdata[VPW];
			hit_q   <= 1'b0;
			ev_q    <= 1'b0;
			found_q <= 1'b0;
			fr_q    <= '0;
			vic_q   <= '0;
		end else if (state_q == apr_pkg::ST_ACCESS) begin
			if (at_vp) begin
				hit_q <= c_p[0];
				if (c_p[0]) begin
					fr_q <= c_fr[0];
				end else if (free) begin
					fr_q <= fu_q[FRW-1:0];
				end
			end
			if (c_p[0] && (!found_q || c_age[0] < best_q)) begin
				found_q <= 1'b1;
				best_q  <= c_age[0];
				vic_q   <= idx_q;
				vfr_q   <= c_fr[0];
			end
		end else if (is_full) begin
			ev_q <= found_q;
			fr_q <= found_q ? vfr_q : '0;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_hit_q <= hit_q;
			out_fr_q  <= fr_q;
			out_ev_q  <= ev_q;
			out_vic_q <= ev_q ? vic_q : '0;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OW'({out_vic_q, out_ev_q, out_fr_q, out_hit_q});

`ifndef ASSERT_OFF
	a_fu_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fu_q <= FUW'(FRAMES))
		else $error("frame count beyond frame total");
	a_hit_no_evict: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_hit_q && out_ev_q))
		else $error("result both hit and evicted");
	a_ring_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apr_pkg::ST_IDLE) |-> (idx_q == '0))
		else $error("ring not aligned while idle");
	a_evict_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == apr_pkg::ST_EVICT) |-> !free)
		else $error("eviction pass with free frames");
`endif

endmodule
`default_nettype wire

// File: tb/sv/apr_checker.sv
// Checker for the aging page replacement block: watches both stream channels,
// predicts each result from its own copy of the page table and compares.
// Depends on nothing but the block's port widths.
`timescale 1ns / 100ps
module apr_checker #(
	parameter int NPAGES = 128,
	parameter int NFRAMES = 64,
	parameter int AGEW = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	input  logic        s_tready,
	input  logic [7:0]  s_tdata,
	input  logic        s_tuser,
	input  logic        m_tvalid,
	input  logic        m_tready,
	input  logic [15:0] m_tdata,
	output int          errors,
	output int          pending
);
	// packed from the top bit down: victim_page, evicted, frame, hit
	typedef struct packed {
		logic [6:0] victim;
		logic       evicted;
		logic [5:0] frame;
		logic       hit;
	} lookup_t;

	logic            present [NPAGES];
	logic            refd [NPAGES];
	logic            dirty [NPAGES];
	logic [5:0]      frame_of [NPAGES];
	logic [AGEW-1:0] age [NPAGES];
	int              used;
	lookup_t         lookups_due [$];

	// Predict one beat and update the shadow page table
	function automatic lookup_t predict_lookup(logic tick, logic [6:0] vp, logic wr);
		lookup_t r;
		int      v;
		bit      found;
		r = '0;
		if (tick) begin
			for (int p = 0; p < NPAGES; p++) begin
				age[p] = age[p] >> 1;
				if (present[p] && refd[p]) begin
					age[p][AGEW-1] = 1'b1;
					refd[p] = 1'b0;
				end
			end
		end else if (present[vp]) begin
			r.hit = 1'b1;
			refd[vp] = 1'b1;
			if (wr) dirty[vp] = 1'b1;
			r.frame = frame_of[vp];
		end else begin
			if (used < NFRAMES) begin
				r.frame = used[5:0];
				used++;
			end else begin
				found = 0;
				v = 0;
				for (int p = 0; p < NPAGES; p++)
					if (present[p] && (!found || age[p] < age[v])) begin
						found = 1;
						v = p;
					end
				if (found) begin
					r.evicted = 1'b1;
					r.victim = v[6:0];
					r.frame = frame_of[v];
					present[v] = 0; refd[v] = 0; dirty[v] = 0;
					frame_of[v] = '0; age[v] = '0;
				end
			end
			present[vp] = 1'b1; refd[vp] = 0; dirty[vp] = 0;
			age[vp] = '0; frame_of[vp] = r.frame;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		lookup_t got, want;
		if (!arst_n) begin
			for (int p = 0; p < NPAGES; p++) begin
				present[p] = 0; refd[p] = 0; dirty[p] = 0;
				frame_of[p] = '0; age[p] = '0;
			end
			used = 0;
			errors = 0;
			lookups_due.delete();
			pending = 0;
		end else begin
			if (s_tvalid && s_tready)
				lookups_due.push_back(predict_lookup(s_tuser, s_tdata[6:0], s_tdata[7]));
			if (m_tvalid && m_tready) begin
				got = m_tdata[14:0];
				if (lookups_due.size() == 0) begin
					$error("unexpected result beat %h", m_tdata);
					errors++;
				end else begin
					want = lookups_due.pop_front();
					if (got.hit !== want.hit) begin
						$error("hit: expected %0d, got %0d", want.hit, got.hit);
						errors++;
					end
					if (got.frame !== want.frame) begin
						$error("frame: expected %0d, got %0d", want.frame, got.frame);
						errors++;
					end
					if (got.evicted !== want.evicted) begin
						$error("evicted: expected %0d, got %0d", want.evicted, got.evicted);
						errors++;
					end
					if (got.victim !== want.victim) begin
						$error("victim_page: expected %0d, got %0d", want.victim, got.victim);
						errors++;
					end
				end
			end
			pending = lookups_due.size();
		end
	end
endmodule

// File: tb/sv/tb_top.sv
// Top of the aging page replacement testbench: clock, reset, stimulus and verdict.
// Depends on aging_page_replacement and apr_checker.
`timescale 1ns / 100ps
module tb_top;
	localparam int N_RANDOM = 1880;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;   // virt_page, is_write
	logic        s_tuser = 0;    // func
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [15:0] m_tdata;        // hit, frame, evicted, victim_page
	int          errors, pending;
	bit          sink_hold = 0;

	always begin
		#4 clk = 1;
		#4 clk = 0;
	end

	aging_page_replacement DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	apr_checker u_checker (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.errors(errors), .pending(pending)
	);

	function automatic int gap_len();
		return ($urandom_range(0, 9) == 0) ? $urandom_range(20, 300) : $urandom_range(0, 3);
	endfunction

	// Send one beat; optional random gap beforehand
	task automatic send_beat(logic tick, logic [6:0] vp, logic wr, bit gaps);
		int g;
		g = gaps ? gap_len() : 0;
		repeat (g) @(negedge clk);
		s_tuser = tick;
		s_tdata = {wr, vp};
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		s_tvalid = 1'b0;
	endtask

	// Receiver: random stalls, or a long hold-off when asked
	initial begin
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (sink_hold) begin
				m_tready <= 1'b0;
			end else if ($urandom_range(0, 3) == 0) begin
				m_tready <= 1'b0;
				repeat (gap_len()) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Stimulus
	initial begin
		int   hot_base;
		logic [6:0] vp;
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		// directed: tick on empty table, extremes, hit, write hit, write miss
		send_beat(1, 7'h7f, 1, 0);
		send_beat(0, 7'd0, 0, 0);
		send_beat(0, 7'd127, 1, 0);
		send_beat(0, 7'd0, 1, 0);
		send_beat(0, 7'd127, 0, 0);
		send_beat(1, 7'd0, 0, 0);
		send_beat(0, 7'd85, 1, 0);
		send_beat(0, 7'd42, 0, 0);
		send_beat(1, 7'd0, 0, 0);
		send_beat(0, 7'd85, 0, 0);
		// long receiver hold-off while sender keeps offering
		sink_hold = 1;
		fork
			begin
				repeat (600) @(negedge clk);
				sink_hold = 0;
			end
			for (int i = 0; i < 8; i++)
				send_beat(0, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 0);
		join
		// pause until every result is in
		wait (pending == 0);
		// random: a drifting hot set so hits, ticks and evictions all occur
		hot_base = 0;
		for (int i = 0; i < N_RANDOM; i++) begin
			if (i % 150 == 0) hot_base = $urandom_range(0, 127);
			if ($urandom_range(0, 5) == 0)
				send_beat(1, 7'($urandom_range(0, 127)), 1'($urandom_range(0, 1)), 1);
			else begin
				vp = ($urandom_range(0, 2) == 0) ? 7'($urandom_range(0, 127))
					: 7'(hot_base + $urandom_range(0, 79));
				send_beat(0, vp, 1'($urandom_range(0, 1)), ($urandom_range(0, 3) == 0));
			end
		end
		wait (pending == 0);
		repeat (300) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

	// Watchdog
	initial begin
		#100ms;
		$display("Verification failed");
		$finish;
	end
endmodule
